### rtl/rlpd_pkg.sv
// rlpd_pkg: widths, codes, microcode word layout and the microcode program
// for the rate-limited pd joint controller
// depends on nothing; every other file of the block imports it
package rlpd_pkg;

   localparam int DATA_W     = 32;
   localparam int GAIN_W     = 31;
   localparam int STIME_W    = 24;
   localparam int JOINT_W    = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int MUL_A_W    = 33;
   localparam int MUL_B_W    = 32;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;

   localparam logic [STIME_W-1:0] STEP_TIME_RESET     = 24'd33554;
   localparam logic [GAIN_W-1:0]  STEP_TIME_INV_RESET = 31'd32768000;

   // register indexes on the csr channel
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P        = 3'd0,
      CSR_GAIN_D        = 3'd1,
      CSR_MAX_RATE      = 3'd2,
      CSR_STEP_TIME     = 3'd3,
      CSR_STEP_TIME_INV = 3'd4
   } csr_reg_type;

   // microcode addresses
   typedef enum logic [3:0] {
      STEP_IDLE     = 4'd0,
      STEP_LOAD     = 4'd1,
      STEP_MUL_RATE = 4'd2,
      STEP_CLAMP    = 4'd3,
      STEP_MUL_STEP = 4'd4,
      STEP_UPDATE   = 4'd5,
      STEP_MUL_P    = 4'd6,
      STEP_ACC_P    = 4'd7,
      STEP_EMIT     = 4'd8
   } step_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_RATE,
      MUL_STEP,
      MUL_P,
      MUL_D
   } mul_sel_type;

   typedef enum logic [1:0] {
      RATE_HOLD,
      RATE_ZERO,
      RATE_CLAMP
   } rate_op_type;

   typedef enum logic [1:0] {
      SP_HOLD,
      SP_LOAD,
      SP_UPDATE
   } sp_op_type;

   typedef enum logic {
      JMP_NONE,
      JMP_HELD
   } jmp_type;

   // one control word
   typedef struct packed {
      mul_sel_type mul_sel;
      rate_op_type rate_op;
      sp_op_type   sp_op;
      logic        acc_load;
      logic        mem_wr;
      logic        out_load;
      jmp_type     jmp;
      step_type    jmp_target;
      logic        last;
   } ucode_type;

   // microcode program
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '0;
      w.jmp_target = STEP_IDLE;
      case (step)
         STEP_LOAD: begin
            w.sp_op      = SP_LOAD;
            w.rate_op    = RATE_ZERO;
            w.jmp        = JMP_HELD;
            w.jmp_target = STEP_MUL_P;
         end
         STEP_MUL_RATE: begin
            w.mul_sel = MUL_RATE;
         end
         STEP_CLAMP: begin
            w.rate_op = RATE_CLAMP;
         end
         STEP_MUL_STEP: begin
            w.mul_sel = MUL_STEP;
         end
         STEP_UPDATE: begin
            w.sp_op  = SP_UPDATE;
            w.mem_wr = 1'b1;
         end
         STEP_MUL_P: begin
            w.mul_sel = MUL_P;
         end
         STEP_ACC_P: begin
            w.acc_load = 1'b1;
            w.mul_sel  = MUL_D;
         end
         STEP_EMIT: begin
            w.out_load = 1'b1;
            w.last     = 1'b1;
         end
         default: begin
            w.last = 1'b0;
         end
      endcase
      return w;
   endfunction

endpackage

### rtl/rlpd_if.sv
// rlpd_if: valid/ready channel interfaces for requests, responses and csr writes
// depends on rlpd_pkg for field widths
interface rlpd_req_if import rlpd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [JOINT_W-1:0]        joint;
   logic signed [DATA_W-1:0]  measured_position;
   logic signed [DATA_W-1:0]  measured_velocity;
   logic signed [DATA_W-1:0]  target_position;
   logic                      time_advanced;

   modport source (output valid, func, joint, measured_position, measured_velocity,
                   target_position, time_advanced, input ready);
   modport sink   (input valid, func, joint, measured_position, measured_velocity,
                   target_position, time_advanced, output ready);
endinterface

interface rlpd_rsp_if import rlpd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [JOINT_W-1:0]        joint_out;
   logic signed [DATA_W-1:0]  drive;
   logic signed [DATA_W-1:0]  desired_position;
   logic signed [DATA_W-1:0]  desired_rate;

   modport source (output valid, joint_out, drive, desired_position, desired_rate,
                   input ready);
   modport sink   (input valid, joint_out, drive, desired_position, desired_rate,
                   output ready);
endinterface

interface rlpd_csr_if import rlpd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/rlpd_mul.sv
// rlpd_mul: shared signed multiplier with a registered product
// depends on rlpd_pkg for operand and product widths
module rlpd_mul import rlpd_pkg::*; (
   input  logic                      clock,
   input  logic                      enable,
   input  logic signed [MUL_A_W-1:0] op_a,
   input  logic signed [MUL_B_W-1:0] op_b,
   output logic signed [PROD_W-1:0]  product
);

   logic signed [PROD_W-1:0] product_ff;
   logic signed [PROD_W-1:0] product_in;

   // full-width product, held when no step uses the multiplier
   always_comb begin
      product_in = enable ? op_a * op_b : product_ff;
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

### rtl/rate_limited_pd_joint_controller_unit.sv
// rate_limited_pd_joint_controller_unit: top level, microcoded sequencer, setpoint
// store and output register; depends on rlpd_pkg, rlpd_if and rlpd_mul
//
// Usage:
//  req_bus carries one transaction per item. func = 0 copies measured_position
//  into the setpoint of the joint and gives no response; the sequencer stays at
//  rest and the block stays ready for the next item. func = 1 runs a control
//  step: the setpoint moves toward target_position at a rate clamped to
//  +-max_rate (only if time_advanced), then drive = kp*err + kd*rate error.
//  A joint index at or above JOINTS is dropped without a response.
//  rsp_bus gives one transaction per control step: joint, drive, setpoint, rate.
//  csr_bus writes gain_p, gain_d, max_rate, step_time and step_time_inverse by
//  index; it is always ready, other indexes are ignored.
//  The response is registered out of the emit step; when time did not advance,
//  the rate and setpoint steps are skipped. No new request is taken until the
//  sequencer is back at rest. The single shared multiplier forms four products
//  per step (two when time is held), each in its own microcode step. Reset clears
//  the sequencer, the response valid, both gains and max_rate, and presets the
//  step times; the setpoint store is not cleared and must be loaded before a
//  control step. A stalled response is held in the output register; the
//  sequencer waits in its last step until the register is free, while a pending
//  init transaction is still taken once the sequencer is back at rest.
module rate_limited_pd_joint_controller_unit import rlpd_pkg::*; #(
   parameter int JOINTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   rlpd_req_if.sink    req_bus,
   rlpd_rsp_if.source  rsp_bus,
   rlpd_csr_if.sink    csr_bus
);

   localparam int IDX_W   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int JEXT_W  = 9;
   localparam int Q16_W   = PROD_W - 16;
   localparam int Q24_W   = PROD_W - 24;
   localparam int WIDE_W  = Q16_W + 1;

   // saturate a wide signed value to 32 bits
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(32'sh7fffffff);
      lo = WIDE_W'(-33'sh080000000);
      if (v > hi) begin
         return DATA_W'(hi);
      end else if (v < lo) begin
         return DATA_W'(lo);
      end
      return DATA_W'(v);
   endfunction

   // sequencer and item registers
   step_type                  pc_ff, pc_in;
   logic [JOINT_W-1:0]        joint_ff;
   logic signed [DATA_W-1:0]  pos_ff, vel_ff, tgt_ff;
   logic                      adv_ff;

   // datapath registers
   logic signed [DATA_W-1:0]  mem_q_ff;
   logic signed [DATA_W-1:0]  sp_ff, sp_in;
   logic signed [DATA_W-1:0]  rate_ff, rate_in;
   logic signed [Q16_W-1:0]   acc_ff, acc_in;

   // csr registers
   logic [GAIN_W-1:0]         gain_p_ff, gain_d_ff, max_rate_ff, step_time_inv_ff;
   logic [STIME_W-1:0]        step_time_ff;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [JOINT_W-1:0]        rsp_joint_ff;
   logic signed [DATA_W-1:0]  rsp_drive_ff, rsp_sp_ff, rsp_rate_ff;

   // setpoint store
   logic signed [DATA_W-1:0]  sp_mem [JOINTS];
   logic                      mem_we;
   logic [IDX_W-1:0]          mem_wa;
   logic signed [DATA_W-1:0]  mem_wd;

   ucode_type                 uc;
   logic                      req_accept, csr_accept, in_range, emit_go, init_wr;
   logic [JEXT_W-1:0]         req_joint_ext, joint_ext;
   logic [IDX_W-1:0]          req_idx, joint_idx;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic                      mul_en;
   logic signed [PROD_W-1:0]  prod;
   logic signed [Q16_W-1:0]   prod_q16, lim, neg_lim;
   logic signed [Q24_W-1:0]   prod_q24;
   logic signed [DATA_W-1:0]  rate_clamped;
   logic signed [WIDE_W-1:0]  sp_sum, drive_sum;

   // handshakes and joint decode
   assign req_bus.ready  = (pc_ff == STEP_IDLE);
   assign csr_bus.ready  = 1'b1;
   assign req_accept     = req_bus.valid && req_bus.ready;
   assign csr_accept     = csr_bus.valid && csr_bus.ready;
   assign req_joint_ext  = JEXT_W'(req_bus.joint);
   assign joint_ext      = JEXT_W'(joint_ff);
   assign req_idx        = req_joint_ext[IDX_W-1:0];
   assign joint_idx      = joint_ext[IDX_W-1:0];
   assign in_range       = req_joint_ext < JEXT_W'(JOINTS);
   assign init_wr        = req_accept && !req_bus.func && in_range;

   // control word of the current step
   assign uc = ucode_rom(pc_ff);

   // multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (uc.mul_sel)
         MUL_RATE: begin
            mul_a = MUL_A_W'(tgt_ff) - MUL_A_W'(sp_ff);
            mul_b = signed'({1'b0, step_time_inv_ff});
         end
         MUL_STEP: begin
            mul_a = MUL_A_W'(rate_ff);
            mul_b = signed'({{(MUL_B_W - STIME_W){1'b0}}, step_time_ff});
         end
         MUL_P: begin
            mul_a = MUL_A_W'(sp_ff) - MUL_A_W'(pos_ff);
            mul_b = signed'({1'b0, gain_p_ff});
         end
         MUL_D: begin
            mul_a = MUL_A_W'(rate_ff) - MUL_A_W'(vel_ff);
            mul_b = signed'({1'b0, gain_d_ff});
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign mul_en = (uc.mul_sel != MUL_NONE);

   rlpd_mul u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   // product scaling, floor by arithmetic shift
   assign prod_q16 = Q16_W'(prod >>> 16);
   assign prod_q24 = Q24_W'(prod >>> 24);

   // rate clamp to +-max_rate
   assign lim     = signed'(Q16_W'({1'b0, max_rate_ff}));
   assign neg_lim = -lim;
   always_comb begin
      if (prod_q16 > lim) begin
         rate_clamped = DATA_W'(lim);
      end else if (prod_q16 < neg_lim) begin
         rate_clamped = DATA_W'(neg_lim);
      end else begin
         rate_clamped = DATA_W'(prod_q16);
      end
   end

   // setpoint update and drive sum
   assign sp_sum    = WIDE_W'(prod_q24) + WIDE_W'(sp_ff);
   assign drive_sum = WIDE_W'(acc_ff) + WIDE_W'(prod_q16);

   // datapath next values
   always_comb begin
      case (uc.sp_op)
         SP_LOAD:   sp_in = mem_q_ff;
         SP_UPDATE: sp_in = sat32(sp_sum);
         default:   sp_in = sp_ff;
      endcase
      case (uc.rate_op)
         RATE_ZERO:  rate_in = '0;
         RATE_CLAMP: rate_in = rate_clamped;
         default:    rate_in = rate_ff;
      endcase
      acc_in = uc.acc_load ? prod_q16 : acc_ff;
   end

   // step counter with conditional jump
   assign emit_go = uc.out_load && (!rsp_valid_ff || rsp_bus.ready);
   always_comb begin
      pc_in = pc_ff;
      if (pc_ff == STEP_IDLE) begin
         if (req_accept && req_bus.func && in_range) begin
            pc_in = STEP_LOAD;
         end
      end else if (uc.out_load && !emit_go) begin
         pc_in = pc_ff;
      end else if (uc.last) begin
         pc_in = STEP_IDLE;
      end else if ((uc.jmp == JMP_HELD) && !adv_ff) begin
         pc_in = uc.jmp_target;
      end else begin
         pc_in = step_type'(4'(pc_ff + 4'd1));
      end
   end

   // response valid
   always_comb begin
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state and csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff            <= STEP_IDLE;
         rsp_valid_ff     <= 1'b0;
         gain_p_ff        <= '0;
         gain_d_ff        <= '0;
         max_rate_ff      <= '0;
         step_time_ff     <= STEP_TIME_RESET;
         step_time_inv_ff <= STEP_TIME_INV_RESET;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_accept) begin
            case (csr_bus.index)
               CSR_GAIN_P:        gain_p_ff        <= csr_bus.data[GAIN_W-1:0];
               CSR_GAIN_D:        gain_d_ff        <= csr_bus.data[GAIN_W-1:0];
               CSR_MAX_RATE:      max_rate_ff      <= csr_bus.data[GAIN_W-1:0];
               CSR_STEP_TIME:     step_time_ff     <= csr_bus.data[STIME_W-1:0];
               CSR_STEP_TIME_INV: step_time_inv_ff <= csr_bus.data[GAIN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // item capture and datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         joint_ff <= req_bus.joint;
         pos_ff   <= req_bus.measured_position;
         vel_ff   <= req_bus.measured_velocity;
         tgt_ff   <= req_bus.target_position;
         adv_ff   <= req_bus.time_advanced;
      end
      sp_ff   <= sp_in;
      rate_ff <= rate_in;
      acc_ff  <= acc_in;
      if (emit_go) begin
         rsp_joint_ff <= joint_ff;
         rsp_drive_ff <= sat32(drive_sum);
         rsp_sp_ff    <= sp_ff;
         rsp_rate_ff  <= rate_ff;
      end
   end

   // setpoint store, one write port and one registered read port
   assign mem_we = init_wr || uc.mem_wr;
   assign mem_wa = uc.mem_wr ? joint_idx : req_idx;
   assign mem_wd = uc.mem_wr ? sp_in : req_bus.measured_position;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sp_mem[mem_wa] <= mem_wd;
      end
      if (req_accept) begin
         mem_q_ff <= sp_mem[req_idx];
      end
   end

   // response channel
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.joint_out        = rsp_joint_ff;
   assign rsp_bus.drive            = rsp_drive_ff;
   assign rsp_bus.desired_position = rsp_sp_ff;
   assign rsp_bus.desired_rate     = rsp_rate_ff;

   // a response only appears out of the emit step
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pc_ff == STEP_EMIT))
      else $error("response valid rose outside the emit step");

   // when time is held the rate update and setpoint update are skipped
   a_held_skip: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_LOAD) && !adv_ff |=> (pc_ff == STEP_MUL_P) && (rate_ff == '0))
      else $error("held step did not skip to the drive products");

   // the emitted rate lies within the configured limit
   a_rate_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == STEP_EMIT) |->
         (MUL_A_W'(rate_ff) <= signed'(MUL_A_W'({1'b0, max_rate_ff})))
         && (MUL_A_W'(rate_ff) >= -signed'(MUL_A_W'({1'b0, max_rate_ff}))))
      else $error("rate outside the limit");

endmodule
